// File: src/tw_pkg.sv
// ----------------------------------------------------------------------------
// tw_pkg: shared types and round functions of the modified 3-Way decryptor.
// Holds the block type, the linear and nonlinear steps and the round constants.
// ----------------------------------------------------------------------------
package tw_pkg;

    // Number of full rounds; one more key addition follows them.
    localparam int unsigned ROUND_COUNT = 11;

    // Round constant generator.
    localparam logic [15:0] RC_START = 16'hb1b1;
    localparam logic [16:0] RC_POLY  = 17'h11011;

    // Vendor whitening word.
    localparam logic [31:0] VENDOR_WHITE = 32'h7483a3fd;

    // One 96-bit block as three 32-bit words.
    typedef struct packed {
        logic [31:0] w2;
        logic [31:0] w1;
        logic [31:0] w0;
    } t_block;

    // Round constant of round idx, worked out at elaboration.
    function automatic logic [15:0] rc_at(input int unsigned idx);
        logic [16:0] rc;
        rc = {1'b0, RC_START};
        for (int unsigned i = 0; i < idx; i++) begin
            rc = {rc[15:0], 1'b0};
            if (rc[16]) begin
                rc = rc ^ RC_POLY;
            end
        end
        return rc[15:0];
    endfunction

    // Linear mixing step.
    function automatic t_block theta(input t_block b);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        t_block o;
        x = b.w0;
        y = b.w1;
        z = b.w2;
        o.w0 = x ^ (x >> 16) ^ (y << 16) ^ (y >> 16) ^ (z << 16) ^
               (y >> 24) ^ (z << 8) ^ (z >> 8) ^ (x << 24) ^
               (z >> 16) ^ (x << 16) ^ (z >> 24) ^ (x << 8);
        o.w1 = y ^ (y >> 16) ^ (z << 16) ^ (z >> 16) ^ (x << 16) ^
               (z >> 24) ^ (x << 8) ^ (x >> 8) ^ (y << 24) ^
               (x >> 16) ^ (y << 16) ^ (x >> 24) ^ (y << 8);
        o.w2 = z ^ (z >> 16) ^ (x << 16) ^ (x >> 16) ^ (y << 16) ^
               (x >> 24) ^ (y << 8) ^ (y >> 8) ^ (z << 24) ^
               (y >> 16) ^ (z << 16) ^ (y >> 24) ^ (z << 8);
        return o;
    endfunction

    // Bit order reversal of one word.
    function automatic logic [31:0] bit_rev(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

    // Reverse the whole 96-bit block.
    function automatic t_block mu(input t_block b);
        t_block o;
        o.w0 = bit_rev(b.w2);
        o.w1 = bit_rev(b.w1);
        o.w2 = bit_rev(b.w0);
        return o;
    endfunction

    // Nonlinear step.
    function automatic t_block gamma(input t_block b);
        t_block o;
        o.w0 = b.w0 ^ (~b.w2 | b.w1);
        o.w1 = b.w1 ^ (~b.w0 | b.w2);
        o.w2 = b.w2 ^ (~b.w1 | b.w0);
        return o;
    endfunction

    // One round body: theta, pi1, gamma, pi2.
    function automatic t_block rho(input t_block b);
        t_block t;
        t = theta(b);
        t.w0 = {t.w0[9:0], t.w0[31:10]};
        t.w2 = {t.w2[30:0], t.w2[31]};
        t = gamma(t);
        t.w2 = {t.w2[9:0], t.w2[31:10]};
        t.w0 = {t.w0[30:0], t.w0[31]};
        return t;
    endfunction

    // Key and round constant addition.
    function automatic t_block add_key(input t_block b, input t_block k,
                                       input logic [15:0] rc);
        t_block o;
        o.w0 = b.w0 ^ k.w0 ^ {rc, 16'h0000};
        o.w1 = b.w1 ^ k.w1;
        o.w2 = b.w2 ^ k.w2 ^ {16'h0000, rc};
        return o;
    endfunction

endpackage

// File: src/tw_front.sv
// ----------------------------------------------------------------------------
// tw_front: entry cell of the decryption chain.
// Applies the vendor whitening and the initial mu, then registers the word.
// ----------------------------------------------------------------------------
module tw_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tw_pkg::t_block i_block,
    output logic           o_valid,
    output tw_pkg::t_block o_block
);
    import tw_pkg::*;

    logic   r_valid;
    t_block r_block;
    t_block n_block;

    // Whitening: w2 takes w0, w0 takes w1, w1 takes the fixed word.
    always_comb begin
        t_block t;
        t.w2 = i_block.w2 ^ i_block.w0;
        t.w0 = i_block.w0 ^ i_block.w1;
        t.w1 = i_block.w1 ^ VENDOR_WHITE;
        n_block = mu(t);
    end

    // Valid flag is control state and is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        r_block <= n_block;
    end

    assign o_valid = r_valid;
    assign o_block = r_block;

endmodule

// File: src/tw_round_cell.sv
// ----------------------------------------------------------------------------
// tw_round_cell: one round of the decryption chain.
// Adds the round key and constant, runs rho and hands the word on.
// ----------------------------------------------------------------------------
module tw_round_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tw_pkg::t_block i_block,
    input  tw_pkg::t_block i_key,
    input  logic [15:0]    i_rc,
    output logic           o_valid,
    output tw_pkg::t_block o_block
);
    import tw_pkg::*;

    logic   r_valid;
    t_block r_block;
    t_block n_block;

    // Round body.
    assign n_block = rho(add_key(i_block, i_key, i_rc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_block <= n_block;
    end

    assign o_valid = r_valid;
    assign o_block = r_block;

endmodule

// File: src/tw_final_cell.sv
// ----------------------------------------------------------------------------
// tw_final_cell: last cell of the decryption chain.
// Adds the last round key and constant, then applies theta and mu.
// ----------------------------------------------------------------------------
module tw_final_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tw_pkg::t_block i_block,
    input  tw_pkg::t_block i_key,
    input  logic [15:0]    i_rc,
    output logic           o_valid,
    output tw_pkg::t_block o_block
);
    import tw_pkg::*;

    logic   r_valid;
    t_block r_block;
    t_block n_block;

    // Closing key addition and output transform.
    assign n_block = mu(theta(add_key(i_block, i_key, i_rc)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_block <= n_block;
    end

    assign o_valid = r_valid;
    assign o_block = r_block;

endmodule

// File: src/threeway_block_decrypt.sv
// ----------------------------------------------------------------------------
// threeway_block_decrypt: modified 3-Way decryptor, 96-bit block and key.
// Key registers on an APB port feed a chain of registered round cells.
// ----------------------------------------------------------------------------
// The block takes one ciphertext word every clock cycle and never raises
// busy. Each word runs through a chain of thirteen registered cells (entry
// whitening, eleven rounds, closing transform), so its plaintext appears on
// the o_plain_word ports with o_strobe once it has passed through all of
// them. The strobe lasts one cycle and the receiver cannot hold it off. The
// decryption key is derived from the key registers into a register of its
// own; write the key only while no word is in the chain.
module threeway_block_decrypt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_cipher_word_zero,
    input  logic [31:0] i_cipher_word_one,
    input  logic [31:0] i_cipher_word_two,
    // Result channel
    output logic        o_strobe,
    output logic [31:0] o_plain_word_zero,
    output logic [31:0] o_plain_word_one,
    output logic [31:0] o_plain_word_two,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tw_pkg::*;

    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;

    t_block      r_key;
    t_block      r_dkey;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        accept;
    t_block      in_block;
    logic        chain_valid [ROUND_COUNT + 1];
    t_block      chain_block [ROUND_COUNT + 1];
    logic        out_valid;
    t_block      out_block;

    // The chain never stalls.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;

    // Register writes.
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KEY0: r_key.w0 <= pwdata;
                REG_KEY1: r_key.w1 <= pwdata;
                REG_KEY2: r_key.w2 <= pwdata;
                default:  ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (cfg_idx)
            REG_KEY0: prdata = r_key.w0;
            REG_KEY1: prdata = r_key.w1;
            REG_KEY2: prdata = r_key.w2;
            default:  prdata = '0;
        endcase
    end

    // Decryption key: theta then mu of the cipher key.
    always_ff @(posedge i_clk) begin
        r_dkey <= mu(theta(r_key));
    end

    // Entry cell.
    assign in_block.w0 = i_cipher_word_zero;
    assign in_block.w1 = i_cipher_word_one;
    assign in_block.w2 = i_cipher_word_two;

    tw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_block (in_block),
        .o_valid (chain_valid[0]),
        .o_block (chain_block[0])
    );

    // Round cells, one per round.
    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        tw_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_block (chain_block[g]),
            .i_key   (r_dkey),
            .i_rc    (rc_at(g)),
            .o_valid (chain_valid[g + 1]),
            .o_block (chain_block[g + 1])
        );
    end

    // Closing cell.
    tw_final_cell u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[ROUND_COUNT]),
        .i_block (chain_block[ROUND_COUNT]),
        .i_key   (r_dkey),
        .i_rc    (rc_at(ROUND_COUNT)),
        .o_valid (out_valid),
        .o_block (out_block)
    );

    assign o_strobe          = out_valid;
    assign o_plain_word_zero = out_block.w0;
    assign o_plain_word_one  = out_block.w1;
    assign o_plain_word_two  = out_block.w2;

`ifndef NO_ASSERTIONS
    // Every accepted word leaves the chain after the full latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##13 o_strobe)
        else $error("accepted word did not produce a result");

    // No result appears without a word accepted at the matching time.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##13 !o_strobe)
        else $error("result without an accepted word");

    // A write to the first key register lands in that register.
    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (cfg_idx == REG_KEY0)) |=> (r_key.w0 == $past(pwdata)))
        else $error("key word zero write lost");
`endif

endmodule

// File: verif/tw_decrypt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tw_decrypt_checker: plaintext checker for the modified 3-Way decryptor.
// Mirrors the key registers from APB writes and computes the plaintext of
// every accepted cipher word. Each strobed result is compared field by field
// with the oldest pending plaintext.
// ----------------------------------------------------------------------------
module tw_decrypt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel as seen by the block
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_cipher_word_zero,
    input  logic [31:0] i_cipher_word_one,
    input  logic [31:0] i_cipher_word_two,
    // Result channel as driven by the block
    input  logic        i_strobe,
    input  logic [31:0] i_plain_word_zero,
    input  logic [31:0] i_plain_word_one,
    input  logic [31:0] i_plain_word_two,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // Status for the test top
    output int          o_mismatch_count,
    output int          o_plain_pending
);

    localparam int          NUM_ROUNDS   = 11;
    localparam logic [16:0] RC_SEED      = 17'h0b1b1;
    localparam logic [16:0] RC_FEEDBACK  = 17'h11011;
    localparam logic [31:0] WHITEN_WORD  = 32'h7483a3fd;
    localparam int          REPORT_LIMIT = 10;

    // Key register indexes, taken from paddr[3:2].
    localparam logic [1:0] KEY_IDX_ZERO = 2'd0;
    localparam logic [1:0] KEY_IDX_ONE  = 2'd1;
    localparam logic [1:0] KEY_IDX_TWO  = 2'd2;

    // Blocks are kept as {word two, word one, word zero}.
    logic [95:0] key_mirror;
    logic [95:0] expected_plain [$];
    int          mismatches;

    // One output word of the linear mix; a is the word itself, b and c the
    // next two words in cyclic order.
    function automatic logic [31:0] theta_word(input logic [31:0] a,
                                               input logic [31:0] b,
                                               input logic [31:0] c);
        return a ^ (a >> 16) ^ (a << 16) ^ (a << 24) ^ (a << 8) ^
               (b << 16) ^ (b >> 16) ^ (b >> 24) ^
               (c << 16) ^ (c << 8) ^ (c >> 8) ^ (c >> 16) ^ (c >> 24);
    endfunction

    function automatic logic [95:0] lin_mix(input logic [95:0] v);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        x = v[31:0];
        y = v[63:32];
        z = v[95:64];
        return {theta_word(z, x, y), theta_word(y, z, x), theta_word(x, y, z)};
    endfunction

    // Reversing all 96 bits swaps words zero and two and flips each word.
    function automatic logic [95:0] bit_flip(input logic [95:0] v);
        logic [95:0] o;
        for (int i = 0; i < 96; i++) begin
            o[i] = v[95 - i];
        end
        return o;
    endfunction

    function automatic logic [95:0] nonlin_mix(input logic [95:0] v);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        x = v[31:0];
        y = v[63:32];
        z = v[95:64];
        return {z ^ (~y | x), y ^ (~x | z), x ^ (~z | y)};
    endfunction

    // Round body: linear mix, word rotations, nonlinear mix, rotations back.
    function automatic logic [95:0] round_body(input logic [95:0] v);
        logic [95:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        t = lin_mix(v);
        x = t[31:0];
        y = t[63:32];
        z = t[95:64];
        x = {x[9:0], x[31:10]};
        z = {z[30:0], z[31]};
        t = nonlin_mix({z, y, x});
        x = t[31:0];
        y = t[63:32];
        z = t[95:64];
        z = {z[9:0], z[31:10]};
        x = {x[30:0], x[31]};
        return {z, y, x};
    endfunction

    // Full decryption of one block under the given cipher key.
    function automatic logic [95:0] decrypt_block(input logic [95:0] cipher,
                                                  input logic [95:0] key);
        logic [95:0] round_key;
        logic [95:0] s;
        logic [16:0] rc;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        round_key = bit_flip(lin_mix(key));
        x = cipher[31:0];
        y = cipher[63:32];
        z = cipher[95:64];
        // Vendor whitening, applied in this order.
        z = z ^ x;
        x = x ^ y;
        y = y ^ WHITEN_WORD;
        s = bit_flip({z, y, x});
        rc = RC_SEED;
        for (int r = 0; r <= NUM_ROUNDS; r++) begin
            s = s ^ round_key ^ {16'h0000, rc[15:0], 32'h0, rc[15:0], 16'h0000};
            if (r < NUM_ROUNDS) begin
                s = round_body(s);
            end
            rc = {rc[15:0], 1'b0};
            if (rc[16]) begin
                rc = rc ^ RC_FEEDBACK;
            end
        end
        return bit_flip(lin_mix(s));
    endfunction

    // Check results, then record new words, then track key writes.
    always @(posedge i_clk) begin : observe
        logic [95:0] got;
        logic [95:0] want;
        logic [2:0]  field_bad;
        if (!i_rst_n) begin
            key_mirror = '0;
            expected_plain.delete();
            mismatches = 0;
        end else begin
            if (i_strobe) begin
                got = {i_plain_word_two, i_plain_word_one, i_plain_word_zero};
                if (expected_plain.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: plaintext word with none pending: %h %h %h",
                                 $time, got[31:0], got[63:32], got[95:64]);
                    end
                end else begin
                    want = expected_plain.pop_front();
                    field_bad = '0;
                    for (int f = 0; f < 3; f++) begin
                        if (got[32*f +: 32] !== want[32*f +: 32]) begin
                            field_bad[f] = 1'b1;
                        end
                    end
                    if (field_bad != '0) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: plaintext mismatch, fields %b: expected %h %h %h, got %h %h %h",
                                     $time, field_bad, want[31:0], want[63:32], want[95:64],
                                     got[31:0], got[63:32], got[95:64]);
                        end
                    end
                end
            end
            if (start && !busy) begin
                expected_plain.push_back(decrypt_block(
                    {i_cipher_word_two, i_cipher_word_one, i_cipher_word_zero},
                    key_mirror));
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (paddr[3:2])
                    KEY_IDX_ZERO: key_mirror[31:0]  = pwdata;
                    KEY_IDX_ONE:  key_mirror[63:32] = pwdata;
                    KEY_IDX_TWO:  key_mirror[95:64] = pwdata;
                    default: ;
                endcase
            end
        end
        o_mismatch_count <= mismatches;
        o_plain_pending  <= expected_plain.size();
    end

endmodule

// File: verif/tb_threeway_block_decrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threeway_block_decrypt: test top for the modified 3-Way decryptor.
// Drives directed and random cipher words under a series of keys written over
// APB, with sender idling in phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_threeway_block_decrypt;

    localparam int          RANDOM_WORDS   = 1800;
    localparam int          NUM_PHASES     = 8;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [31:0] WHITEN_WORD    = 32'h7483a3fd;

    // Key register addresses; the last one decodes to no register.
    localparam logic [3:0] ADDR_KEY_ZERO = 4'h0;
    localparam logic [3:0] ADDR_KEY_ONE  = 4'h4;
    localparam logic [3:0] ADDR_KEY_TWO  = 4'h8;
    localparam logic [3:0] ADDR_UNMAPPED = 4'hc;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_cipher_word_zero = '0;
    logic [31:0] i_cipher_word_one = '0;
    logic [31:0] i_cipher_word_two = '0;
    logic        o_strobe;
    logic [31:0] o_plain_word_zero;
    logic [31:0] o_plain_word_one;
    logic [31:0] o_plain_word_two;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatch_count;
    int          plain_pending;
    int          quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    threeway_block_decrypt dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cipher_word_zero (i_cipher_word_zero),
        .i_cipher_word_one  (i_cipher_word_one),
        .i_cipher_word_two  (i_cipher_word_two),
        .o_strobe           (o_strobe),
        .o_plain_word_zero  (o_plain_word_zero),
        .o_plain_word_one   (o_plain_word_one),
        .o_plain_word_two   (o_plain_word_two),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    tw_decrypt_checker plain_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cipher_word_zero (i_cipher_word_zero),
        .i_cipher_word_one  (i_cipher_word_one),
        .i_cipher_word_two  (i_cipher_word_two),
        .i_strobe           (o_strobe),
        .i_plain_word_zero  (o_plain_word_zero),
        .i_plain_word_one   (o_plain_word_one),
        .i_plain_word_two   (o_plain_word_two),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .o_mismatch_count   (mismatch_count),
        .o_plain_pending    (plain_pending)
    );

    // Watchdog: end the run after too many cycles with no word moving.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Random word biased toward all-zero, all-one and single-bit patterns.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom();
        endcase
    endfunction

    // One cipher word, preceded by a random idle stretch with noise on the data.
    task automatic send_cipher(input logic [31:0] w0, input logic [31:0] w1,
                               input logic [31:0] w2, input int idle_pct);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_cipher_word_zero <= $urandom();
            i_cipher_word_one <= $urandom();
            i_cipher_word_two <= $urandom();
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_cipher_word_zero <= w0;
        i_cipher_word_one <= w1;
        i_cipher_word_two <= w2;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic write_key(input logic [3:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stop sending and wait for the pipeline to drain completely.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (plain_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int idle_pct;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset key, back to back.
        send_cipher(32'h0, 32'h0, 32'h0, 0);
        send_cipher('1, '1, '1, 0);
        send_cipher('1, 32'h0, 32'h0, 0);
        send_cipher(32'h0, '1, 32'h0, 0);
        send_cipher(32'h0, 32'h0, '1, 0);
        send_cipher(32'h0, WHITEN_WORD, 32'h0, 0);
        send_cipher(32'h12345678, 32'h12345678, 32'h12345678, 0);
        send_cipher(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 0);
        send_cipher(32'h55555555, 32'haaaaaaaa, 32'h55555555, 0);
        send_cipher(32'h00000001, 32'h0, 32'h0, 0);
        send_cipher(32'h0, 32'h0, 32'h80000000, 0);
        send_cipher(32'h80000000, 32'h00000001, WHITEN_WORD, 0);
        send_cipher(32'hdeadbeef, 32'hdeadbeef, 32'h0, 0);

        // Random phases, each under a new idling mode; the key is rewritten in full or in part, or kept.
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    write_key(ADDR_KEY_ZERO, '1);
                    write_key(ADDR_KEY_ONE, '1);
                    write_key(ADDR_KEY_TWO, '1);
                end
                1: begin
                    write_key(ADDR_KEY_ZERO, '0);
                    write_key(ADDR_KEY_ONE, '0);
                    write_key(ADDR_KEY_TWO, '0);
                end
                2: begin
                    write_key(ADDR_KEY_ZERO, 32'haaaaaaaa);
                    write_key(ADDR_KEY_ONE, 32'h55555555);
                    write_key(ADDR_KEY_TWO, 32'haaaaaaaa);
                    write_key(ADDR_UNMAPPED, $urandom());
                end
                default: begin
                    // Sometimes only part of the key changes.
                    if (p == 3 || $urandom_range(2) != 0) write_key(ADDR_KEY_ZERO, pick_word());
                    if (p == 3 || $urandom_range(2) != 0) write_key(ADDR_KEY_ONE, pick_word());
                    if (p == 3 || $urandom_range(2) != 0) write_key(ADDR_KEY_TWO, pick_word());
                    if ($urandom_range(1) != 0) write_key(ADDR_UNMAPPED, $urandom());
                end
            endcase
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 58;
                default: idle_pct = 7;
            endcase
            for (int n = 0; n < RANDOM_WORDS / NUM_PHASES; n++) begin
                w0 = pick_word();
                w1 = pick_word();
                w2 = pick_word();
                // Occasionally cancel parts of the whitening.
                case ($urandom_range(19))
                    0: w1 = WHITEN_WORD;
                    1: w1 = w0;
                    2: w2 = w0;
                    default: ;
                endcase
                send_cipher(w0, w1, w2, idle_pct);
            end
        end

        settle();
        if (mismatch_count == 0 && plain_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
